// File: rtl/core/lskv_pkg.sv
// lskv_pkg: shared types and constants of the key/value store core
`default_nettype none
package lskv_pkg;
  localparam int LOG_SLOTS = 1024;
  localparam int SLOT_W = $clog2(LOG_SLOTS);
  localparam int CNT_W = SLOT_W + 1;
  localparam int KEY_W = 16;
  localparam int KEY_IN_W = 32;
  localparam int VAL_W = 64;
  localparam int OP_W = 3;
  localparam int ST_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_READ = 3'd0, OP_WRITE = 3'd1, OP_REMOVE = 3'd2, OP_FORMAT = 3'd3, OP_COMPACT = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK = 2'd0, ST_INVALID = 2'd1, ST_NOTFOUND = 2'd2, ST_FULL = 2'd3
  } stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_SRCH_RD, S_SRCH_CMP, S_SRCH_END, S_RD_WAIT, S_WR_CHK, S_WR_PREP,
    S_CMP_RDI, S_CMP_RDL, S_CMP_WR, S_CMP_END, S_APPLY, S_SH_CHK, S_SH_WR, S_FIN
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
  } idx_ent_t;

  typedef struct packed {
    logic  load;
    logic  i_clr;
    logic  i_inc;
    logic  i_set_pos;
    logic  idx_ra_next;
    logic  log_ra_idx;
    logic  srch_cap;
    logic  hold_key;
    logic  cmp_wr;
    logic  cmp_done;
    logic  upd_slot;
    logic  append_new;
    logic  log_append;
    logic  shift_wr;
    logic  idx_dec;
    logic  fmt;
    logic  rd_cap;
    logic  set_stat;
    stat_t stat;
    logic  push;
  } cmd_t;

  typedef struct packed {
    op_t              op;
    logic             key_bad;
    logic             match;
    logic             i_last;
    logic             idx_empty;
    logic             log_full;
    logic             idx_full;
    logic             val_eq;
    logic             found;
    logic             out_free;
    logic [CNT_W-1:0] log_used;
    logic [CNT_W-1:0] idx_used;
  } sts_t;
endpackage
`default_nettype wire

// File: rtl/core/lskv_ram.sv
// lskv_ram: generic single write port memory with registered read
`default_nettype none
module lskv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/lskv_ctrl.sv
// lskv_ctrl: operation sequencer of the key/value store core
`default_nettype none
module lskv_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire lskv_pkg::sts_t sts,
  output lskv_pkg::cmd_t     cmd,
  output lskv_pkg::state_t   state
);
  import lskv_pkg::*;

  state_t state_r, state_nxt;
  assign state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  logic keyed;
  assign keyed = sts.op inside {OP_READ, OP_WRITE, OP_REMOVE};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_DECODE;
      S_DECODE: begin
        if (keyed && sts.key_bad) state_nxt = S_FIN;
        else if (keyed) state_nxt = sts.idx_empty ? S_SRCH_END : S_SRCH_RD;
        else if (sts.op == OP_COMPACT) begin
          if (sts.idx_full) state_nxt = S_FIN;
          else state_nxt = sts.idx_empty ? S_CMP_END : S_CMP_RDI;
        end else state_nxt = S_FIN;
      end
      S_SRCH_RD: state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: state_nxt = (sts.match || sts.i_last) ? S_SRCH_END : S_SRCH_RD;
      S_SRCH_END: begin
        if (!sts.found) state_nxt = (sts.op == OP_WRITE) ? S_WR_PREP : S_FIN;
        else if (sts.op == OP_READ) state_nxt = S_RD_WAIT;
        else if (sts.op == OP_WRITE) state_nxt = S_WR_CHK;
        else state_nxt = S_WR_PREP;
      end
      S_RD_WAIT: state_nxt = S_FIN;
      S_WR_CHK: state_nxt = sts.val_eq ? S_FIN : S_WR_PREP;
      S_WR_PREP: begin
        if (!sts.log_full) state_nxt = S_APPLY;
        else if (sts.idx_full) state_nxt = S_FIN;
        else state_nxt = sts.idx_empty ? S_CMP_END : S_CMP_RDI;
      end
      S_CMP_RDI: state_nxt = S_CMP_RDL;
      S_CMP_RDL: state_nxt = S_CMP_WR;
      S_CMP_WR: state_nxt = sts.i_last ? S_CMP_END : S_CMP_RDI;
      S_CMP_END: state_nxt = (sts.op == OP_COMPACT) ? S_FIN : S_APPLY;
      S_APPLY: state_nxt = (sts.op == OP_REMOVE) ? S_SH_CHK : S_FIN;
      S_SH_CHK: state_nxt = sts.i_last ? S_FIN : S_SH_WR;
      S_SH_WR: state_nxt = S_SH_CHK;
      S_FIN: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.stat = ST_OK;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: cmd.load = in_tvalid;
      S_DECODE: begin
        cmd.i_clr = 1'b1;
        if (keyed && sts.key_bad) begin
          cmd.set_stat = 1'b1;
          cmd.stat = ST_INVALID;
        end else if (sts.op == OP_FORMAT) cmd.fmt = 1'b1;
        else if (sts.op == OP_COMPACT && sts.idx_full) begin
          cmd.set_stat = 1'b1;
          cmd.stat = ST_FULL;
        end
      end
      S_SRCH_CMP: begin
        if (sts.match) cmd.srch_cap = 1'b1;
        else if (!sts.i_last) cmd.i_inc = 1'b1;
      end
      S_SRCH_END: begin
        if (!sts.found && sts.op == OP_READ) begin
          cmd.set_stat = 1'b1;
          cmd.stat = ST_NOTFOUND;
        end
      end
      S_RD_WAIT: cmd.rd_cap = 1'b1;
      S_WR_PREP: begin
        cmd.i_clr = 1'b1;
        if (sts.log_full && sts.idx_full) begin
          cmd.set_stat = 1'b1;
          cmd.stat = ST_FULL;
        end
      end
      S_CMP_RDL: begin
        cmd.log_ra_idx = 1'b1;
        cmd.hold_key = 1'b1;
      end
      S_CMP_WR: begin
        cmd.cmp_wr = 1'b1;
        cmd.i_inc = !sts.i_last;
      end
      S_CMP_END: cmd.cmp_done = 1'b1;
      S_APPLY: begin
        cmd.log_append = 1'b1;
        if (sts.op == OP_REMOVE) cmd.i_set_pos = 1'b1;
        else if (sts.found) cmd.upd_slot = 1'b1;
        else cmd.append_new = 1'b1;
      end
      S_SH_CHK: begin
        cmd.idx_ra_next = 1'b1;
        cmd.idx_dec = sts.i_last;
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.i_inc = 1'b1;
      end
      S_FIN: cmd.push = sts.out_free;
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/core/lskv_dp.sv
// lskv_dp: counters, index and log memories and result register
`default_nettype none
module lskv_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire lskv_pkg::cmd_t                 cmd,
  output lskv_pkg::sts_t                      sts,
  input  wire logic [lskv_pkg::OP_W-1:0]      in_op,
  input  wire logic [lskv_pkg::KEY_IN_W-1:0]  in_key,
  input  wire logic [lskv_pkg::VAL_W-1:0]     in_val,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [lskv_pkg::ST_W-1:0]           out_status,
  output logic [lskv_pkg::VAL_W-1:0]          out_value
);
  import lskv_pkg::*;

  op_t               op_r;
  logic [KEY_IN_W-1:0] key_r;
  logic [VAL_W-1:0]  val_r;
  logic              found_r;
  logic [CNT_W-1:0]  pos_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  i_r;
  logic [KEY_W-1:0]  hkey_r;
  logic [CNT_W-1:0]  log_used_r, idx_used_r;
  logic              bank_r;
  stat_t             stat_r;
  logic [VAL_W-1:0]  rd_r;
  logic              out_valid_r;
  logic [ST_W-1:0]   out_stat_r;
  logic [VAL_W-1:0]  out_rd_r;

  logic [CNT_W-1:0]  i_p1;
  idx_ent_t          idx_rdata, idx_wdata;
  logic              idx_we;
  logic [SLOT_W-1:0] idx_waddr, idx_raddr;
  logic [VAL_W-1:0]  log_rd0, log_rd1, log_rdata, log_wdata0, log_wdata1;
  logic [SLOT_W-1:0] log_raddr, log_waddr0, log_waddr1;
  logic              log_we0, log_we1;
  logic [VAL_W-1:0]  app_val;

  assign i_p1 = i_r + CNT_W'(1);
  assign idx_raddr = cmd.idx_ra_next ? i_p1[SLOT_W-1:0] : i_r[SLOT_W-1:0];
  assign log_raddr = cmd.log_ra_idx ? idx_rdata.slot : slot_r;
  assign log_rdata = bank_r ? log_rd1 : log_rd0;
  assign app_val = (op_r == OP_REMOVE) ? '0 : val_r;

  always_comb begin
    idx_we = 1'b1;
    idx_waddr = i_r[SLOT_W-1:0];
    idx_wdata = idx_rdata;
    if (cmd.cmp_wr) begin
      idx_wdata = '{key: hkey_r, slot: i_r[SLOT_W-1:0]};
    end else if (cmd.upd_slot) begin
      idx_waddr = pos_r[SLOT_W-1:0];
      idx_wdata = '{key: key_r[KEY_W-1:0], slot: log_used_r[SLOT_W-1:0]};
    end else if (cmd.append_new) begin
      idx_waddr = idx_used_r[SLOT_W-1:0];
      idx_wdata = '{key: key_r[KEY_W-1:0], slot: log_used_r[SLOT_W-1:0]};
    end else if (!cmd.shift_wr) begin
      idx_we = 1'b0;
    end
  end

  // appends go to the live bank, compaction copies into the other one
  always_comb begin
    log_we0 = (cmd.log_append && !bank_r) || (cmd.cmp_wr && bank_r);
    log_we1 = (cmd.log_append && bank_r) || (cmd.cmp_wr && !bank_r);
    log_waddr0 = bank_r ? i_r[SLOT_W-1:0] : log_used_r[SLOT_W-1:0];
    log_waddr1 = bank_r ? log_used_r[SLOT_W-1:0] : i_r[SLOT_W-1:0];
    log_wdata0 = bank_r ? log_rdata : app_val;
    log_wdata1 = bank_r ? app_val : log_rdata;
  end

  lskv_ram #(.WIDTH($bits(idx_ent_t)), .DEPTH(LOG_SLOTS)) u_idx (
    .clk(clk), .we(idx_we), .waddr(idx_waddr), .wdata(idx_wdata),
    .raddr(idx_raddr), .rdata(idx_rdata)
  );
  lskv_ram #(.WIDTH(VAL_W), .DEPTH(LOG_SLOTS)) u_log0 (
    .clk(clk), .we(log_we0), .waddr(log_waddr0), .wdata(log_wdata0),
    .raddr(log_raddr), .rdata(log_rd0)
  );
  lskv_ram #(.WIDTH(VAL_W), .DEPTH(LOG_SLOTS)) u_log1 (
    .clk(clk), .we(log_we1), .waddr(log_waddr1), .wdata(log_wdata1),
    .raddr(log_raddr), .rdata(log_rd1)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(in_op);
      key_r <= in_key;
      val_r <= in_val;
    end
    if (cmd.hold_key) hkey_r <= idx_rdata.key;
    if (cmd.srch_cap) begin
      pos_r <= i_r;
      slot_r <= idx_rdata.slot;
    end
    if (cmd.i_clr) i_r <= '0;
    else if (cmd.i_set_pos) i_r <= pos_r;
    else if (cmd.i_inc) i_r <= i_p1;
    if (cmd.rd_cap) rd_r <= log_rdata;
    else if (cmd.load) rd_r <= '0;
    if (cmd.set_stat) stat_r <= cmd.stat;
    else if (cmd.load) stat_r <= ST_OK;
    if (cmd.push) begin
      out_stat_r <= stat_r;
      out_rd_r <= rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      log_used_r <= '0;
      idx_used_r <= '0;
      bank_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) found_r <= 1'b0;
      else if (cmd.srch_cap) found_r <= 1'b1;
      if (cmd.fmt) begin
        log_used_r <= '0;
        idx_used_r <= '0;
      end else begin
        if (cmd.cmp_done) begin
          bank_r <= !bank_r;
          log_used_r <= idx_used_r;
        end else if (cmd.log_append) begin
          log_used_r <= log_used_r + CNT_W'(1);
        end
        if (cmd.append_new) idx_used_r <= idx_used_r + CNT_W'(1);
        else if (cmd.idx_dec) idx_used_r <= idx_used_r - CNT_W'(1);
      end
      if (cmd.push) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.op = op_r;
    sts.key_bad = (key_r[KEY_IN_W-1:KEY_W] != '0);
    sts.match = (idx_rdata.key == key_r[KEY_W-1:0]);
    sts.i_last = (i_p1 >= idx_used_r);
    sts.idx_empty = (idx_used_r == '0);
    sts.log_full = (log_used_r == CNT_W'(LOG_SLOTS));
    sts.idx_full = (idx_used_r == CNT_W'(LOG_SLOTS));
    sts.val_eq = (log_rdata == val_r);
    sts.found = found_r;
    sts.out_free = !out_valid_r || out_ready;
    sts.log_used = log_used_r;
    sts.idx_used = idx_used_r;
  end

  assign out_valid = out_valid_r;
  assign out_status = out_stat_r;
  assign out_value = out_rd_r;
endmodule
`default_nettype wire

// File: rtl/core/log_structured_key_value_store_core.sv
// log_structured_key_value_store_core: top level of the log-structured key/value store
//
//   channel | direction | fields (low bit first)
//   in_     | input     | tdata: op[2:0], key[34:3], write_value[98:35]
//   out_    | output    | tdata: status[1:0], read_value[65:2]
//
// one item at a time; a lookup walks the index one entry at a time through a read
// state and a compare state, a compaction reads the index, reads the log and writes
// the copy for each entry, and a removal walks the rest of the index to close the gap.
// no clearing pass after reset: only counters, the log bank select, the found flag, out_valid and the state are reset.
// the result sits in an output register, so the next item is taken while it waits.
`default_nettype none
module log_structured_key_value_store_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [103:0] in_tdata,  // op, key, write_value
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [71:0]       out_tdata  // status, read_value
);
  import lskv_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  state_t state;
  logic [ST_W-1:0]  st;
  logic [VAL_W-1:0] rv;

  lskv_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .sts(sts), .cmd(cmd), .state(state)
  );

  lskv_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_tdata[OP_W-1:0]),
    .in_key(in_tdata[OP_W+KEY_IN_W-1:OP_W]),
    .in_val(in_tdata[OP_W+KEY_IN_W+VAL_W-1:OP_W+KEY_IN_W]),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(st), .out_value(rv)
  );

  assign out_tdata = {6'd0, rv, st};

  // every live key owns a distinct record in the log
  a_idx_le_log: assert property (@(posedge clk) disable iff (!rst_n)
    sts.idx_used <= sts.log_used) else $error("index count above log count");
  a_log_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.log_used <= CNT_W'(LOG_SLOTS)) else $error("log count out of range");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (!in_tready && state == S_DECODE))
    else $error("item taken while busy");
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && out_tvalid) |-> out_tready) else $error("result overwritten");
endmodule
`default_nettype wire

// File: tb/sv/log_structured_key_value_store_core_tb.sv
// log_structured_key_value_store_core_tb: random and directed checks of the key/value store core
`default_nettype none
module log_structured_key_value_store_core_tb;
  import lskv_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  typedef struct packed {
    stat_t       status;
    logic [63:0] value;
  } kv_result_t;

  class kv_scoreboard;
    logic [63:0] slot_val[LOG_SLOTS];
    logic [15:0] live_key[LOG_SLOTS];
    int unsigned live_slot[LOG_SLOTS];
    int unsigned n_log;
    int unsigned n_live;
    kv_result_t pending[$];
    int errors;

    function void clear_store();
      n_log = 0;
      n_live = 0;
      foreach (slot_val[i]) slot_val[i] = '0;
    endfunction

    function int find_live(logic [15:0] k);
      for (int i = 0; i < n_live; i++) if (live_key[i] == k) return i;
      return -1;
    endfunction

    function void append_val(logic [63:0] v);
      if (n_log < LOG_SLOTS) begin
        slot_val[n_log] = v;
        n_log++;
      end
    endfunction

    function bit squeeze_log();
      logic [63:0] keep[LOG_SLOTS];
      int unsigned n;
      if (n_live >= LOG_SLOTS) return 0;
      n = n_live;
      for (int i = 0; i < n; i++) keep[i] = slot_val[live_slot[i]];
      foreach (slot_val[i]) slot_val[i] = '0;
      n_log = 0;
      for (int i = 0; i < n; i++) begin
        live_slot[i] = i;
        append_val(keep[i]);
      end
      return 1;
    endfunction

    function void note_item(logic [2:0] op, logic [31:0] key, logic [63:0] wv);
      kv_result_t r;
      int pos;
      logic [15:0] k;
      k = key[15:0];
      r.status = ST_OK;
      r.value = '0;
      if (op <= OP_REMOVE && key > 32'hffff) begin
        r.status = ST_INVALID;
      end else if (op == OP_READ) begin
        pos = find_live(k);
        if (pos < 0) r.status = ST_NOTFOUND;
        else r.value = slot_val[live_slot[pos]];
      end else if (op == OP_WRITE) begin
        pos = find_live(k);
        if (pos >= 0 && slot_val[live_slot[pos]] == wv) begin
          r.status = ST_OK;
        end else if (n_log >= LOG_SLOTS && !squeeze_log()) begin
          r.status = ST_FULL;
        end else begin
          pos = find_live(k);
          if (pos >= 0) begin
            live_slot[pos] = n_log;
          end else if (n_live < LOG_SLOTS) begin
            live_key[n_live] = k;
            live_slot[n_live] = n_log;
            n_live++;
          end
          append_val(wv);
        end
      end else if (op == OP_REMOVE) begin
        pos = find_live(k);
        if (pos < 0) begin
          r.status = ST_OK;
        end else if (n_log >= LOG_SLOTS && !squeeze_log()) begin
          r.status = ST_FULL;
        end else begin
          append_val('0);
          pos = find_live(k);
          if (pos >= 0) begin
            for (int i = pos; i + 1 < n_live; i++) begin
              live_key[i] = live_key[i+1];
              live_slot[i] = live_slot[i+1];
            end
            n_live--;
          end
        end
      end else if (op == OP_FORMAT) begin
        clear_store();
      end else if (op == OP_COMPACT) begin
        if (!squeeze_log()) r.status = ST_FULL;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [71:0] d);
      kv_result_t e;
      if (pending.size() == 0) begin
        $error("result with no item waiting: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[1:0] != e.status) begin
        $error("status expected %0d actual %0d", e.status, d[1:0]);
        errors++;
      end
      if (d[65:2] != e.value) begin
        $error("read_value expected %h actual %h", e.value, d[65:2]);
        errors++;
      end
      if (d[71:66] != '0) begin
        $error("padding expected 0 actual %h", d[71:66]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [103:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [71:0] out_tdata;

  kv_scoreboard sb;
  bit quiet_tail = 0;
  bit hold_sink = 0;
  int idle_cycles = 0;
  logic [15:0] used_keys[$];

  log_structured_key_value_store_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    sb = new();
    sb.clear_store();
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_item(in_tdata[2:0], in_tdata[34:3], in_tdata[98:35]);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver with random stall bursts and a long hold while hold_sink is set
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_sink) begin
        out_tready <= 0;
        repeat (3000) @(posedge clk);
        hold_sink = 0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1;
        @(posedge clk);
      end
    end
  end

  // tvalid stays up between back to back items and drops only in a gap or a drain
  task automatic send_item(logic [2:0] op, logic [31:0] key, logic [63:0] wv);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {5'b0, wv, key, op};
    @(posedge clk iff in_tready);
  endtask

  task automatic drain_all();
    in_tvalid <= 0;
    @(posedge clk iff sb.pending.size() == 0);
  endtask

  function automatic logic [31:0] pick_key();
    int c;
    c = $urandom_range(0, 19);
    if (c == 0) return $urandom() | 32'h0001_0000;
    if (c == 1) return $urandom_range(0, 1) ? 32'h0000_ffff : 32'h0;
    if (c < 4 || used_keys.size() == 0) begin
      logic [31:0] k;
      k = {16'h0, 16'($urandom())};
      if (used_keys.size() < 40) used_keys.push_back(k[15:0]);
      return k;
    end
    return {16'h0, used_keys[$urandom_range(0, used_keys.size() - 1)]};
  endfunction

  function automatic logic [63:0] pick_val();
    int c;
    c = $urandom_range(0, 9);
    if (c == 0) return '0;
    if (c == 1) return '1;
    if (c < 4) return 64'($urandom_range(0, 3));
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [31:0] k;
    int c;
    logic [2:0] op;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes and special cases
    send_item(OP_READ, 32'h0, '0);
    send_item(OP_REMOVE, 32'h5, '0);
    send_item(OP_WRITE, 32'h0, '1);
    send_item(OP_WRITE, 32'hffff, 64'h0);
    send_item(OP_WRITE, 32'hffff, 64'h0);
    send_item(OP_READ, 32'h0, '0);
    send_item(OP_READ, 32'hffff, '0);
    send_item(OP_WRITE, 32'hffff_ffff, '1);
    send_item(OP_READ, 32'h0001_0000, '0);
    send_item(OP_REMOVE, 32'h8000_0000, '0);
    send_item(OP_WRITE, 32'h1234, 64'hdead_beef_0123_4567);
    send_item(OP_WRITE, 32'h0, 64'h5555_aaaa_5555_aaaa);
    send_item(OP_REMOVE, 32'h0, '0);
    send_item(OP_READ, 32'h0, '0);
    send_item(OP_COMPACT, 32'hffff_ffff, '1);
    send_item(OP_READ, 32'h1234, '0);
    send_item(3'd5, 32'h1234, '1);
    send_item(3'd6, 32'h0, '0);
    send_item(3'd7, 32'hffff_ffff, '1);
    send_item(OP_FORMAT, 32'hffff_ffff, '1);
    send_item(OP_READ, 32'h1234, '0);
    send_item(OP_READ, 32'hffff, '0);

    // sender waits out every result
    drain_all();

    // many writes to a few keys grow the log while the receiver holds off
    for (int i = 0; i < 300; i++) begin
      if (i == 20) hold_sink = 1;
      send_item(OP_WRITE, 32'(i % 4), 64'(i));
    end
    send_item(OP_READ, 32'h2, '0);
    drain_all();

    // random mix
    for (int i = 0; i < 250; i++) begin
      if (i == 225) quiet_tail = 1;
      c = $urandom_range(0, 99);
      if (c < 30) op = OP_READ;
      else if (c < 70) op = OP_WRITE;
      else if (c < 88) op = OP_REMOVE;
      else if (c < 91) op = OP_FORMAT;
      else if (c < 96) op = OP_COMPACT;
      else op = 3'($urandom_range(5, 7));
      k = pick_key();
      send_item(op, k, pick_val());
    end

    drain_all();
    repeat (6000) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
